@@ hw/rtl/sliding_window_median_assert.svh @@
// Assertion macros for the running median filter.
// Expects aclk and aresetn in the scope where a macro is used.
`ifndef SLIDING_WINDOW_MEDIAN_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define SWM_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define SWM_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);

`endif

@@ hw/rtl/swm_pkg.sv @@
// Shared types, sizes and helpers for the running median filter.
// No dependencies; used by swm_cell and sliding_window_median.
package swm_pkg;

    localparam int MAX_WINDOW   = 16;
    localparam int SAMPLE_WIDTH = 16;
    localparam int LEN_W        = 5;
    localparam int AGE_W        = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int EFF_W        = $clog2(MAX_WINDOW + 1);

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [AGE_W-1:0]               age_t;
    typedef logic [EFF_W-1:0]               eff_len_t;
    typedef logic [LEN_W-1:0]               cfg_len_t;

    // What one cell shows its two neighbors.
    typedef struct packed {
        sample_t value;
        age_t    age;
        logic    le;    // active and value <= incoming sample
        logic    rem;   // the oldest entry sits at this cell or below it
    } link_t;

    // A length of zero acts as one; lengths above the store size saturate.
    function automatic eff_len_t clamp_length(cfg_len_t raw);
        if (raw == '0) begin
            return eff_len_t'(1);
        end else if (int'(raw) > MAX_WINDOW) begin
            return eff_len_t'(MAX_WINDOW);
        end else begin
            return eff_len_t'(raw);
        end
    endfunction

endpackage

@@ hw/rtl/sliding_window_median.sv @@
// Running median filter over the most recent window_length signed samples.
// Input beats arrive on s_valid/s_ready/s_sample_in; each accepted beat
// gives exactly one result beat on m_valid/m_ready/m_median_out, the
// element at position window_length/2 of the ascending window order
// (upper median for even lengths). The window is kept sorted in a row of
// cells; each beat removes the oldest entry and inserts the new sample
// together, so the result is valid the cycle after acceptance and the block
// takes one beat per cycle while no result is stalled. A stalled result
// holds the output while one more input is not taken; s_ready is low only
// while a result waits and m_ready is low. Reset (aresetn low, synchronous)
// fills the window with zeros and sets the length to 16. A beat on cfg_valid/
// cfg_window_length sets the length (zero acts as one, above 16 saturates)
// and clears the window to zeros in the same cycle; cfg_ready is always high.
// Depends on swm_pkg, swm_cell and sliding_window_median_assert.svh.
`include "sliding_window_median_assert.svh"

module sliding_window_median (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  swm_pkg::sample_t    s_sample_in,
    output logic                m_valid,
    input  logic                m_ready,
    output swm_pkg::sample_t    m_median_out,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  swm_pkg::cfg_len_t   cfg_window_length
);
    import swm_pkg::*;

    eff_len_t eff_len_reg, eff_len_next;
    logic     m_valid_reg, m_valid_next;
    logic     in_beat;
    logic     cfg_beat;
    logic     len_ok;
    age_t     oldest_age;
    age_t     med_idx;
    link_t    links [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] old_vec;
    logic [MAX_WINDOW-1:0] sorted_ok;

    assign cfg_ready  = 1'b1;
    assign cfg_beat   = cfg_valid && cfg_ready;
    assign s_ready    = !m_valid_reg || m_ready;
    assign in_beat    = s_valid && s_ready;
    assign m_valid    = m_valid_reg;
    assign oldest_age = age_t'(eff_len_reg - eff_len_t'(1));
    assign med_idx    = age_t'(eff_len_reg >> 1);
    assign m_median_out = links[med_idx].value;
    assign len_ok     = (eff_len_reg != '0) && (eff_len_reg <= eff_len_t'(MAX_WINDOW));

    for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
        link_t prev_l, next_l;
        logic  active;

        if (i == 0) begin : g_first
            assign prev_l = '{value: '0, age: '0, le: 1'b1, rem: 1'b0};
            assign old_vec[i] = links[i].rem;
        end else begin : g_mid
            assign prev_l = links[i-1];
            assign old_vec[i] = links[i].rem && !links[i-1].rem;
        end

        if (i == MAX_WINDOW - 1) begin : g_last
            assign next_l = '{value: '0, age: '0, le: 1'b0, rem: 1'b1};
            assign sorted_ok[i] = 1'b1;
        end else begin : g_inner
            assign next_l = links[i+1];
            assign sorted_ok[i] = (eff_len_t'(i + 1) >= eff_len_reg) ||
                                  ($signed(links[i].value) <= $signed(links[i+1].value));
        end

        assign active = eff_len_reg > eff_len_t'(i);

        swm_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .clear      (cfg_beat),
            .step       (in_beat),
            .active     (active),
            .init_age   (age_t'(i)),
            .oldest_age (oldest_age),
            .sample     (s_sample_in),
            .prev_link  (prev_l),
            .next_link  (next_l),
            .link       (links[i])
        );
    end

    always_comb begin
        eff_len_next = eff_len_reg;
        if (cfg_beat) begin
            eff_len_next = clamp_length(cfg_window_length);
        end
        m_valid_next = m_valid_reg;
        if (in_beat) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eff_len_reg <= eff_len_t'(MAX_WINDOW);
            m_valid_reg <= 1'b0;
        end else begin
            eff_len_reg <= eff_len_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `SWM_ASSERT_NOW(a_one_oldest, $onehot(old_vec), "not exactly one oldest entry")
    `SWM_ASSERT_NOW(a_sorted, &sorted_ok, "active cells are out of ascending order")
    `SWM_ASSERT_NEXT(a_result_follows, in_beat, m_valid, "accepted beat gave no result")
    `SWM_ASSERT_NEXT(a_len_range, cfg_beat, len_ok, "window length out of range")

endmodule

@@ hw/rtl/swm_cell.sv @@
// One cell of the sorted window chain: a sample and its age.
// Depends on swm_pkg; instantiated in a row by sliding_window_median.
module swm_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              clear,
    input  logic              step,
    input  logic              active,
    input  swm_pkg::age_t     init_age,
    input  swm_pkg::age_t     oldest_age,
    input  swm_pkg::sample_t  sample,
    input  swm_pkg::link_t    prev_link,
    input  swm_pkg::link_t    next_link,
    output swm_pkg::link_t    link
);
    import swm_pkg::*;

    sample_t value_reg, value_next;
    age_t    age_reg, age_next;
    logic    own_le;
    logic    is_old;
    logic    rem_le;
    logic    r_le;
    logic    rm1_le;
    sample_t r_value, rm1_value;
    age_t    r_age, rm1_age;

    assign own_le = active && (value_reg <= sample);
    assign is_old = active && (age_reg == oldest_age);
    assign rem_le = prev_link.rem || is_old;

    assign link.value = value_reg;
    assign link.age   = age_reg;
    assign link.le    = own_le;
    assign link.rem   = rem_le;

    // With the oldest entry taken out, the chain is shorter by one. This cell
    // and the one below see the shortened order through these selections.
    always_comb begin
        r_le      = rem_le ? next_link.le : own_le;
        r_value   = rem_le ? next_link.value : value_reg;
        r_age     = rem_le ? next_link.age : age_reg;
        rm1_le    = prev_link.rem ? own_le : prev_link.le;
        rm1_value = prev_link.rem ? value_reg : prev_link.value;
        rm1_age   = prev_link.rem ? age_reg : prev_link.age;

        value_next = value_reg;
        age_next   = age_reg;
        if (step && active) begin
            if (r_le) begin
                value_next = r_value;
                age_next   = r_age + age_t'(1);
            end else if (rm1_le) begin
                value_next = sample;
                age_next   = '0;
            end else begin
                value_next = rm1_value;
                age_next   = rm1_age + age_t'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            value_reg <= '0;
            age_reg   <= init_age;
        end else begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

endmodule
